/* sv/tcw_pkg.sv */
`default_nettype none

package tcw_pkg;

   localparam int DEF_ROWS = 25;
   localparam int DEF_COLS = 80;

   localparam logic [7:0] CLEAR_ATTR = 8'h0F;
   localparam logic [7:0] BLANK_CHAR = 8'h20;
   localparam logic [7:0] NEWLINE    = 8'h0A;

   localparam logic [2:0] KIND_PUT    = 3'd0;
   localparam logic [2:0] KIND_CURSOR = 3'd1;
   localparam logic [2:0] KIND_CLEAR  = 3'd2;
   localparam logic [2:0] KIND_FILL   = 3'd3;
   localparam logic [2:0] KIND_READ   = 3'd4;

   typedef enum logic [2:0] {
      RAM_IDLE,
      RAM_PUT,
      RAM_BLANK,
      RAM_SCROLL,
      RAM_READ
   } ram_op_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_ADV,
      CUR_NEWLINE,
      CUR_COL0,
      CUR_SET
   } cur_op_type;

   typedef struct packed {
      logic       load_item;
      logic       cnt_clr;
      logic       cnt_inc;
      logic       blank_item;
      logic       rsp_load;
      ram_op_type ram_op;
      cur_op_type cur_op;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       is_nl;
      logic       col_past;
      logic       row_last;
      logic       blank_done;
      logic       scroll_done;
   } status_type;

endpackage

`default_nettype wire

/* sv/tcw_ram.sv */
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

/* sv/tcw_ctrl.sv */
`default_nettype none

module tcw_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire tcw_pkg::status_type status,
   output tcw_pkg::cmd_type        cmd
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_WRITE,
      ST_SCROLL,
      ST_BLANK,
      ST_READ,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '{load_item: 1'b0, cnt_clr: 1'b0, cnt_inc: 1'b0, blank_item: 1'b0,
                   rsp_load: 1'b0, ram_op: tcw_pkg::RAM_IDLE, cur_op: tcw_pkg::CUR_HOLD};

      case (state_ff)
         ST_INIT: begin
            cmd.ram_op  = tcw_pkg::RAM_BLANK;
            cmd.cnt_inc = 1'b1;
            if (status.blank_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (status.kind)
               tcw_pkg::KIND_PUT: begin
                  if (!status.is_nl && !status.col_past) begin
                     cmd.ram_op = tcw_pkg::RAM_PUT;
                     cmd.cur_op = tcw_pkg::CUR_ADV;
                     state_in   = ST_RESP;
                  end else if (!status.row_last) begin
                     cmd.cur_op = tcw_pkg::CUR_NEWLINE;
                     state_in   = status.is_nl ? ST_RESP : ST_WRITE;
                  end else begin
                     // bottom row: row stays, column back to 0, screen scrolls
                     cmd.cur_op  = tcw_pkg::CUR_COL0;
                     cmd.cnt_clr = 1'b1;
                     state_in    = ST_SCROLL;
                  end
               end
               tcw_pkg::KIND_CURSOR: begin
                  cmd.cur_op = tcw_pkg::CUR_SET;
                  state_in   = ST_RESP;
               end
               tcw_pkg::KIND_CLEAR, tcw_pkg::KIND_FILL: begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = ST_BLANK;
               end
               tcw_pkg::KIND_READ: begin
                  cmd.ram_op = tcw_pkg::RAM_READ;
                  state_in   = ST_READ;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_WRITE: begin
            cmd.ram_op = tcw_pkg::RAM_PUT;
            cmd.cur_op = tcw_pkg::CUR_ADV;
            state_in   = ST_RESP;
         end
         ST_SCROLL: begin
            cmd.ram_op  = tcw_pkg::RAM_SCROLL;
            cmd.cnt_inc = 1'b1;
            if (status.scroll_done) begin
               state_in = status.is_nl ? ST_RESP : ST_WRITE;
            end
         end
         ST_BLANK: begin
            cmd.ram_op     = tcw_pkg::RAM_BLANK;
            cmd.blank_item = 1'b1;
            cmd.cnt_inc    = 1'b1;
            if (status.blank_done) begin
               state_in = ST_RESP;
            end
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_RESP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a finished word goes straight to the output register when it is free
      if (state_in == ST_RESP && rsp_free) begin
         cmd.rsp_load = 1'b1;
         state_in     = ST_IDLE;
      end

      rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* sv/tcw_datapath.sv */
`default_nettype none

module tcw_datapath #(
   parameter int ROWS = tcw_pkg::DEF_ROWS,
   parameter int COLS = tcw_pkg::DEF_COLS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [2:0]          req_kind,
   input  wire logic [7:0]          req_char_code,
   input  wire logic [7:0]          req_row_sel,
   input  wire logic [7:0]          req_col_sel,
   input  wire logic [3:0]          req_fill_fg,
   input  wire logic [3:0]          req_fill_bg,
   input  wire logic                csr_wr_en,
   input  wire logic [7:0]          csr_wr_data,
   input  wire tcw_pkg::cmd_type    cmd,
   output tcw_pkg::status_type      status,
   output logic      [4:0]          rsp_cursor_row_out,
   output logic      [6:0]          rsp_cursor_col_out,
   output logic      [7:0]          rsp_cell_char,
   output logic      [7:0]          rsp_cell_attr
);

   localparam int N   = ROWS * COLS;
   localparam int AW  = $clog2(N);
   localparam int CNW = $clog2(N + 1);
   localparam int RW  = $clog2(ROWS);
   localparam int CLW = $clog2(COLS + 1);

   logic [2:0]     kind_ff;
   logic [7:0]     char_ff, rsel_ff, csel_ff;
   logic [3:0]     fg_ff, bg_ff;
   logic [7:0]     attr_ff;
   logic [RW-1:0]  row_ff, row_in, row_clamp, pos_row;
   logic [CLW-1:0] col_ff, col_in, col_clamp, pos_col;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]  pos_addr;
   logic [7:0]     blank_attr;
   logic           scroll_keep;

   logic           ram_we, ram_re;
   logic [AW-1:0]  ram_waddr, ram_raddr;
   logic [15:0]    ram_wdata, ram_rdata;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff <= req_kind;
         char_ff <= req_char_code;
         rsel_ff <= req_row_sel;
         csel_ff <= req_col_sel;
         fg_ff   <= req_fill_fg;
         bg_ff   <= req_fill_bg;
      end
   end

   assign row_clamp = (rsel_ff >= ROWS) ? RW'(ROWS - 1) : rsel_ff[RW-1:0];
   assign col_clamp = (csel_ff >= COLS) ? CLW'(COLS - 1) : csel_ff[CLW-1:0];

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      case (cmd.cur_op)
         tcw_pkg::CUR_ADV: begin
            col_in = col_ff + CLW'(1);
         end
         tcw_pkg::CUR_NEWLINE: begin
            row_in = row_ff + RW'(1);
            col_in = '0;
         end
         tcw_pkg::CUR_COL0: begin
            col_in = '0;
         end
         tcw_pkg::CUR_SET: begin
            row_in = row_clamp;
            col_in = col_clamp;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CNW'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         cnt_ff  <= '0;
         attr_ff <= tcw_pkg::CLEAR_ATTR;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         cnt_ff <= cnt_in;
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
      end
   end

   // cell address of the cursor, or of the clamped position for a cell read
   assign pos_row  = (cmd.ram_op == tcw_pkg::RAM_READ) ? row_clamp : row_ff;
   assign pos_col  = (cmd.ram_op == tcw_pkg::RAM_READ) ? col_clamp : col_ff;
   assign pos_addr = AW'(pos_row) * AW'(COLS) + AW'(pos_col);

   assign blank_attr = (cmd.blank_item && kind_ff == tcw_pkg::KIND_FILL) ?
                       {bg_ff, fg_ff} : tcw_pkg::CLEAR_ATTR;

   // scroll: each write takes the cell read in the cycle before, so the row below lands on the row above
   assign scroll_keep = (cnt_ff < CNW'(N - COLS + 1));

   always_comb begin
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = cnt_ff[AW-1:0];
      ram_raddr = pos_addr;
      ram_wdata = {blank_attr, tcw_pkg::BLANK_CHAR};
      case (cmd.ram_op)
         tcw_pkg::RAM_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = pos_addr;
            ram_wdata = {attr_ff, char_ff};
         end
         tcw_pkg::RAM_BLANK: begin
            ram_we = 1'b1;
         end
         tcw_pkg::RAM_SCROLL: begin
            ram_re    = (cnt_ff < CNW'(N - COLS));
            ram_raddr = AW'(cnt_ff + CNW'(COLS));
            ram_we    = (cnt_ff != '0);
            ram_waddr = AW'(cnt_ff - CNW'(1));
            ram_wdata = scroll_keep ? ram_rdata : {attr_ff, tcw_pkg::BLANK_CHAR};
         end
         tcw_pkg::RAM_READ: begin
            ram_re = 1'b1;
         end
         default: begin
         end
      endcase
   end

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (N)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_cursor_row_out <= 5'(row_in);
         rsp_cursor_col_out <= 7'(col_in);
         if (kind_ff == tcw_pkg::KIND_READ) begin
            rsp_cell_char <= ram_rdata[7:0];
            rsp_cell_attr <= ram_rdata[15:8];
         end else begin
            rsp_cell_char <= '0;
            rsp_cell_attr <= '0;
         end
      end
   end

   assign status.kind        = kind_ff;
   assign status.is_nl       = (char_ff == tcw_pkg::NEWLINE);
   assign status.col_past    = (col_ff >= CLW'(COLS));
   assign status.row_last    = (row_ff == RW'(ROWS - 1));
   assign status.blank_done  = (cnt_ff == CNW'(N - 1));
   assign status.scroll_done = (cnt_ff == CNW'(N));

endmodule

`default_nettype wire

/* sv/text_console_writer_unit.sv */
// Channel  Ports                                     Direction  Handshake
// req      req_kind/char_code/row_sel/col_sel/fill_*  in         req_valid / req_ready
// rsp      rsp_cursor_row_out/col_out, rsp_cell_*    out        rsp_valid / rsp_ready
// csr      csr_wr_data (text attribute)              in         csr_wr_en, no wait
//
// Put char and set cursor go from decode straight to the response; read cell adds a
// read state (registered memory read port), a wrapping put char a write state.
// A scroll adds one read-write sweep over the cell memory.
// Clear and fill sweep the cell memory, one cell written per cycle.
// After reset a clearing pass over all ROWS*COLS cells runs with req_ready low.
// The output register holds a word while rsp_ready is low; the next word is taken
// meanwhile and waits once done until the register frees.
`default_nettype none

module text_console_writer_unit #(
   parameter int ROWS = tcw_pkg::DEF_ROWS,
   parameter int COLS = tcw_pkg::DEF_COLS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] req_kind,
   input  wire logic [7:0] req_char_code,
   input  wire logic [7:0] req_row_sel,
   input  wire logic [7:0] req_col_sel,
   input  wire logic [3:0] req_fill_fg,
   input  wire logic [3:0] req_fill_bg,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic      [4:0] rsp_cursor_row_out,
   output logic      [6:0] rsp_cursor_col_out,
   output logic      [7:0] rsp_cell_char,
   output logic      [7:0] rsp_cell_attr,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);

   tcw_pkg::cmd_type    cmd;
   tcw_pkg::status_type status;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_kind           (req_kind),
      .req_char_code      (req_char_code),
      .req_row_sel        (req_row_sel),
      .req_col_sel        (req_col_sel),
      .req_fill_fg        (req_fill_fg),
      .req_fill_bg        (req_fill_bg),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .cmd                (cmd),
      .status             (status),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_attr      (rsp_cell_attr)
   );

endmodule

`default_nettype wire

/* sv/tcw_checker.sv */
`default_nettype none

module tcw_checker #(
   parameter int ROWS = tcw_pkg::DEF_ROWS,
   parameter int COLS = tcw_pkg::DEF_COLS
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [4:0] rsp_cursor_row_out,
   input wire logic [6:0] rsp_cursor_col_out,
   input wire logic [7:0] rsp_cell_char,
   input wire logic [7:0] rsp_cell_attr
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_row_out)
         && $stable(rsp_cursor_col_out) && $stable(rsp_cell_char) && $stable(rsp_cell_attr))
      else $error("rsp word changed while stalled");

   // clearing pass keeps the request side closed straight after reset
   a_init_closed: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_row_out) < ROWS))
      else $error("cursor row beyond last row");

   // column may sit one past the end while a wrap is pending
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_col_out) <= COLS))
      else $error("cursor column beyond wrap position");

endmodule

bind text_console_writer_unit tcw_checker #(
   .ROWS (ROWS),
   .COLS (COLS)
) u_tcw_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_cursor_row_out (rsp_cursor_row_out),
   .rsp_cursor_col_out (rsp_cursor_col_out),
   .rsp_cell_char      (rsp_cell_char),
   .rsp_cell_attr      (rsp_cell_attr)
);

`default_nettype wire

/* tb/text_console_checker.sv */
`timescale 1ns / 100ps

module text_console_checker #(
   parameter int ROWS = tcw_pkg::DEF_ROWS,
   parameter int COLS = tcw_pkg::DEF_COLS
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [2:0] req_kind,
   input  wire logic [7:0] req_char_code,
   input  wire logic [7:0] req_row_sel,
   input  wire logic [7:0] req_col_sel,
   input  wire logic [3:0] req_fill_fg,
   input  wire logic [3:0] req_fill_bg,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [4:0] rsp_cursor_row_out,
   input  wire logic [6:0] rsp_cursor_col_out,
   input  wire logic [7:0] rsp_cell_char,
   input  wire logic [7:0] rsp_cell_attr,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data,
   output int              fail_count,
   output int              pending,
   output int              scroll_count,
   output int              wrap_count,
   output int              read_count
);

   typedef struct packed {
      logic [4:0] row;
      logic [6:0] col;
      logic [7:0] ch;
      logic [7:0] attr;
   } console_word_type;

   logic [15:0]      cell_mem [ROWS*COLS];
   int unsigned      cursor_y;
   int unsigned      cursor_x;
   logic [7:0]       write_attr;
   console_word_type due_words_q [$];

   function automatic void paint_screen(logic [7:0] attr);
      for (int i = 0; i < ROWS*COLS; i++) cell_mem[i] = {attr, tcw_pkg::BLANK_CHAR};
   endfunction

   function automatic void scroll_screen();
      for (int i = 0; i < (ROWS-1)*COLS; i++) cell_mem[i] = cell_mem[i+COLS];
      for (int i = 0; i < COLS; i++)
         cell_mem[(ROWS-1)*COLS + i] = {write_attr, tcw_pkg::BLANK_CHAR};
      scroll_count++;
   endfunction

   function automatic void line_feed();
      cursor_x = 0;
      cursor_y++;
      if (cursor_y >= ROWS) begin
         scroll_screen();
         cursor_y = ROWS - 1;
      end
   endfunction

   function automatic int unsigned limit_to(logic [7:0] sel, int lim);
      return (sel >= lim) ? lim - 1 : sel;
   endfunction

   function automatic console_word_type run_console_op(logic [2:0] kind, logic [7:0] ch,
         logic [7:0] rs, logic [7:0] cs, logic [3:0] fg, logic [3:0] bg);
      console_word_type w;
      logic [15:0]      cell_word;
      w = '0;
      case (kind)
         tcw_pkg::KIND_PUT: begin
            if (ch == tcw_pkg::NEWLINE) begin
               line_feed();
            end else begin
               if (cursor_x >= COLS) begin
                  wrap_count++;
                  line_feed();
               end
               cell_mem[cursor_y*COLS + cursor_x] = {write_attr, ch};
               cursor_x++;
            end
         end
         tcw_pkg::KIND_CURSOR: begin
            cursor_y = limit_to(rs, ROWS);
            cursor_x = limit_to(cs, COLS);
         end
         tcw_pkg::KIND_CLEAR: paint_screen(tcw_pkg::CLEAR_ATTR);
         tcw_pkg::KIND_FILL:  paint_screen({bg, fg});
         tcw_pkg::KIND_READ: begin
            cell_word = cell_mem[limit_to(rs, ROWS)*COLS + limit_to(cs, COLS)];
            w.ch   = cell_word[7:0];
            w.attr = cell_word[15:8];
            read_count++;
         end
         default: ;
      endcase
      w.row = cursor_y[4:0];
      w.col = cursor_x[6:0];
      return w;
   endfunction

   initial begin
      fail_count   = 0;
      pending      = 0;
      scroll_count = 0;
      wrap_count   = 0;
      read_count   = 0;
   end

   always @(posedge clock) begin
      console_word_type want;
      console_word_type got;
      if (reset) begin
         paint_screen(tcw_pkg::CLEAR_ATTR);
         cursor_y   = 0;
         cursor_x   = 0;
         write_attr = tcw_pkg::CLEAR_ATTR;
         due_words_q.delete();
         pending = 0;
      end else begin
         // response first: a word accepted at this edge cannot answer at it
         if (rsp_valid && rsp_ready) begin
            got = {rsp_cursor_row_out, rsp_cursor_col_out, rsp_cell_char, rsp_cell_attr};
            if (due_words_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected response word row=%0d col=%0d char=%h attr=%h",
                           $realtime, got.row, got.col, got.ch, got.attr);
            end else begin
               want = due_words_q.pop_front();
               if (got.row !== want.row || got.col !== want.col ||
                   got.ch !== want.ch || got.attr !== want.attr) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch exp row=%0d col=%0d char=%h attr=%h",
                               " / got row=%0d col=%0d char=%h attr=%h"}, $realtime,
                              want.row, want.col, want.ch, want.attr,
                              got.row, got.col, got.ch, got.attr);
               end
            end
         end
         if (csr_wr_en) write_attr = csr_wr_data;
         if (req_valid && req_ready)
            due_words_q.push_back(run_console_op(req_kind, req_char_code, req_row_sel,
                                                 req_col_sel, req_fill_fg, req_fill_bg));
         pending = due_words_q.size();
      end
   end

endmodule

/* tb/text_console_writer_unit_test.sv */
`timescale 1ns / 100ps

module text_console_writer_unit_test;

   localparam int ROWS = tcw_pkg::DEF_ROWS;
   localparam int COLS = tcw_pkg::DEF_COLS;
   localparam logic [2:0] KIND_SPARE = 3'd5;
   localparam logic [2:0] KIND_TOP   = 3'd7;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [2:0] req_kind;
   logic [7:0] req_char_code;
   logic [7:0] req_row_sel;
   logic [7:0] req_col_sel;
   logic [3:0] req_fill_fg;
   logic [3:0] req_fill_bg;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [4:0] rsp_cursor_row_out;
   logic [6:0] rsp_cursor_col_out;
   logic [7:0] rsp_cell_char;
   logic [7:0] rsp_cell_attr;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   int fail_count;
   int pending;
   int scroll_count;
   int wrap_count;
   int read_count;
   int words_sent;
   int attr_writes;
   bit send_burst;
   bit take_burst;

   text_console_writer_unit #(.ROWS(ROWS), .COLS(COLS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_char_code(req_char_code),
      .req_row_sel(req_row_sel), .req_col_sel(req_col_sel),
      .req_fill_fg(req_fill_fg), .req_fill_bg(req_fill_bg),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_cursor_row_out(rsp_cursor_row_out), .rsp_cursor_col_out(rsp_cursor_col_out),
      .rsp_cell_char(rsp_cell_char), .rsp_cell_attr(rsp_cell_attr),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   text_console_checker #(.ROWS(ROWS), .COLS(COLS)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_char_code(req_char_code),
      .req_row_sel(req_row_sel), .req_col_sel(req_col_sel),
      .req_fill_fg(req_fill_fg), .req_fill_bg(req_fill_bg),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_cursor_row_out(rsp_cursor_row_out), .rsp_cursor_col_out(rsp_cursor_col_out),
      .rsp_cell_char(rsp_cell_char), .rsp_cell_attr(rsp_cell_attr),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending), .scroll_count(scroll_count),
      .wrap_count(wrap_count), .read_count(read_count)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // worst case is a full-memory pass per word plus both stalls; several times over
   initial begin
      #(300_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: random hold-off per word, bursts with none
   initial begin
      int unsigned hold;
      int          taken;
      rsp_ready  = 1'b0;
      take_burst = 1'b0;
      taken      = 0;
      @(posedge clock);
      forever begin
         if (taken % 40 == 0) take_burst = ($urandom_range(0, 3) == 0);
         hold = take_burst ? 0 : $urandom_range(0, 16);
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         taken++;
      end
   end

   task automatic send_word(logic [2:0] kind, logic [7:0] ch, logic [7:0] rs,
                            logic [7:0] cs, logic [3:0] fg, logic [3:0] bg);
      int unsigned gap;
      gap = send_burst ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_kind      <= kind;
      req_char_code <= ch;
      req_row_sel   <= rs;
      req_col_sel   <= cs;
      req_fill_fg   <= fg;
      req_fill_bg   <= bg;
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      words_sent++;
   endtask

   // idle the request side until every predicted word is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_attr(logic [7:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      attr_writes++;
   endtask

   // mostly in range, often near the clamp edge, sometimes anything
   function automatic logic [7:0] pick_sel(int lim);
      int unsigned p;
      p = $urandom_range(0, 9);
      if (p < 6) return 8'($urandom_range(0, lim - 1));
      else if (p < 8) return 8'($urandom_range(lim - 3, lim + 1));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_random_word();
      int unsigned pick;
      logic [2:0]  k;
      logic [7:0]  ch;
      logic [7:0]  rs;
      logic [7:0]  cs;
      pick = $urandom_range(0, 99);
      ch   = 8'($urandom_range(0, 255));
      rs   = 8'($urandom_range(0, 255));
      cs   = 8'($urandom_range(0, 255));
      if (pick < 50) begin
         k = tcw_pkg::KIND_PUT;
         if ($urandom_range(0, 6) == 0) ch = tcw_pkg::NEWLINE;
      end else if (pick < 68) begin
         k  = tcw_pkg::KIND_CURSOR;
         rs = pick_sel(ROWS);
         cs = pick_sel(COLS);
      end else if (pick < 92) begin
         k  = tcw_pkg::KIND_READ;
         rs = pick_sel(ROWS);
         cs = pick_sel(COLS);
      end else if (pick < 94) begin
         k = tcw_pkg::KIND_CLEAR;
      end else if (pick < 96) begin
         k = tcw_pkg::KIND_FILL;
      end else begin
         k = 3'($urandom_range(KIND_SPARE, KIND_TOP));
      end
      send_word(k, ch, rs, cs, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
   endtask

   initial begin
      logic [7:0] phase_attr [4];
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = tcw_pkg::KIND_PUT;
      req_char_code = '0;
      req_row_sel   = '0;
      req_col_sel   = '0;
      req_fill_fg   = '0;
      req_fill_bg   = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      words_sent    = 0;
      attr_writes   = 0;
      send_burst    = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reset contents and attribute, clamps, wrap and scroll
      send_word(tcw_pkg::KIND_READ,   8'h00, 8'd0,   8'd0,   4'h0, 4'h0);
      send_word(tcw_pkg::KIND_READ,   8'hFF, 8'd255, 8'd255, 4'hF, 4'hF);
      send_word(tcw_pkg::KIND_PUT,    8'h41, 8'd0,   8'd0,   4'h0, 4'h0);
      send_word(tcw_pkg::KIND_PUT,    8'hFF, 8'd0,   8'd0,   4'h0, 4'h0);
      send_word(tcw_pkg::KIND_PUT,    8'h00, 8'd0,   8'd0,   4'h0, 4'h0);
      send_word(tcw_pkg::KIND_READ,   8'h00, 8'd0,   8'd1,   4'h0, 4'h0);
      send_word(tcw_pkg::KIND_CURSOR, 8'h00, 8'd255, 8'd255, 4'h0, 4'h0);
      send_word(tcw_pkg::KIND_PUT,    8'h5A, 8'd0,   8'd0,   4'h0, 4'h0);
      // column now past the end: next char wraps and scrolls from the last row
      send_word(tcw_pkg::KIND_PUT,    8'h51, 8'd0,   8'd0,   4'h0, 4'h0);
      send_word(tcw_pkg::KIND_READ,   8'h00, 8'(ROWS-2), 8'(COLS-1), 4'h0, 4'h0);
      send_word(tcw_pkg::KIND_PUT,    tcw_pkg::NEWLINE, 8'd0, 8'd0, 4'h0, 4'h0);
      send_word(tcw_pkg::KIND_READ,   8'h00, 8'(ROWS-1), 8'd0, 4'h0, 4'h0);
      send_word(tcw_pkg::KIND_CURSOR, 8'h00, 8'd3,   8'(COLS-1), 4'h0, 4'h0);
      send_word(tcw_pkg::KIND_PUT,    8'h78, 8'd0,   8'd0,   4'h0, 4'h0);
      // newline with wrap pending moves one line only
      send_word(tcw_pkg::KIND_PUT,    tcw_pkg::NEWLINE, 8'd0, 8'd0, 4'h0, 4'h0);
      send_word(tcw_pkg::KIND_CURSOR, 8'h00, 8'(ROWS-1), 8'(COLS), 4'h0, 4'h0);
      send_word(tcw_pkg::KIND_FILL,   8'h00, 8'd0,   8'd0,   4'hF, 4'hF);
      send_word(tcw_pkg::KIND_READ,   8'h00, 8'd12,  8'd40,  4'h0, 4'h0);
      send_word(tcw_pkg::KIND_FILL,   8'h00, 8'd0,   8'd0,   4'h3, 4'hA);
      send_word(tcw_pkg::KIND_READ,   8'h00, 8'd0,   8'd0,   4'h0, 4'h0);
      send_word(tcw_pkg::KIND_CLEAR,  8'h00, 8'd0,   8'd0,   4'h0, 4'h0);
      send_word(tcw_pkg::KIND_READ,   8'h00, 8'(ROWS-1), 8'(COLS-1), 4'h0, 4'h0);
      send_word(KIND_SPARE,           8'h41, 8'd1,   8'd1,   4'h1, 4'h1);
      send_word(KIND_TOP,             8'h41, 8'd1,   8'd1,   4'h1, 4'h1);
      send_word(tcw_pkg::KIND_CURSOR, 8'h00, 8'd0,   8'd0,   4'h0, 4'h0);

      phase_attr[0] = 8'hFF;
      phase_attr[1] = 8'h00;
      phase_attr[2] = 8'($urandom_range(0, 255));
      phase_attr[3] = 8'($urandom_range(0, 255));
      for (int phase = 0; phase < 4; phase++) begin
         drain_responses();
         write_attr(phase_attr[phase]);
         for (int n = 0; n < 400; n++) begin
            if (n % 50 == 0) send_burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 199) == 0) drain_responses();
            send_random_word();
         end
      end

      drain_responses();
      repeat (20) @(posedge clock);
      $display("Sent %0d request words over %0d attribute settings.", words_sent, attr_writes);
      $display("Saw %0d scrolls, %0d wraps and %0d cell reads.",
               scroll_count, wrap_count, read_count);
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* text_console_writer_unit.f */
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_ctrl.sv
sv/tcw_datapath.sv
sv/text_console_writer_unit.sv
sv/tcw_checker.sv
tb/text_console_checker.sv
tb/text_console_writer_unit_test.sv
